FILE: src/prq_pkg.sv
// Shared types for the priority ready queue: command and result records,
// operation and status codes. No dependencies.
package prq_pkg;

  // Operation carried by one input transaction
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam int ID_W   = 4;
  localparam int PRIO_W = 8;
  localparam int CNT_OUT_W = 5;

  // Classified command from the front end to the back end
  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } cmd_t;

  // One result record
  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic                 valid;
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

endpackage

FILE: src/prq_front.sv
// Front end: accepts input transactions, decodes and masks them into
// commands, and buffers them in a two-entry queue. Depends on prq_pkg.
module prq_front #(
  parameter int PRIO_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,   // [3:0] proc_id, [11:4] prio, [15:12] zero
  input  logic [0:0]    s_tuser,   // [0] action
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output prq_pkg::cmd_t cmd
);
  import prq_pkg::*;

  localparam int SPW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
  localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((9'd1 << SPW) - 9'd1);

  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // Decode the incoming transaction
  always_comb begin
    cmd_in.op   = s_tuser[0] ? OP_REMOVE : OP_INSERT;
    cmd_in.id   = s_tdata[ID_W-1:0];
    cmd_in.prio = s_tdata[ID_W +: PRIO_W] & PRIO_MASK;
  end

  assign s_tready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = mem[rp];
  assign cnt_next  = 2'(cnt + {1'b0, push} - {1'b0, pop});

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt_next;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cmd_in;
  end

endmodule

FILE: src/prq_back.sv
// Back end: sorted cell chain with per-cell compare and shift, entry count,
// and the result register. Depends on prq_pkg.
module prq_back #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  prq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output prq_pkg::res_t res
);
  import prq_pkg::*;

  localparam int SPW   = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ID_W-1:0]  id_q [DEPTH];
  logic [SPW-1:0]   pr_q [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [DEPTH-1:0] ge;
  logic [SPW-1:0]   npr;
  logic             take;
  logic             full;
  logic             empty;
  logic             ins_go;
  logic             rem_go;
  res_t             res_next;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign cmd_ready = !res_valid || res_ready;
  assign take      = cmd_valid && cmd_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign npr       = cmd.prio[SPW-1:0];
  assign ins_go    = take && (cmd.op == OP_INSERT) && !full;
  assign rem_go    = take && (cmd.op == OP_REMOVE) && !empty;

  // Cell chain: each cell compares against the new priority and shifts
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < count) && (pr_q[i] >= npr);

    always_ff @(posedge clk) begin
      if (ins_go && !ge[i]) begin
        if (i == 0) begin
          id_q[i] <= cmd.id;
          pr_q[i] <= npr;
        end else if (ge[(i == 0) ? 0 : i - 1]) begin
          id_q[i] <= cmd.id;
          pr_q[i] <= npr;
        end else begin
          id_q[i] <= id_q[(i == 0) ? 0 : i - 1];
          pr_q[i] <= pr_q[(i == 0) ? 0 : i - 1];
        end
      end else if (rem_go && (i < DEPTH - 1)) begin
        id_q[i] <= id_q[(i < DEPTH - 1) ? i + 1 : i];
        pr_q[i] <= pr_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Count update
  always_comb begin
    count_next = count;
    if (ins_go) count_next = count + CNT_W'(1);
    if (rem_go) count_next = count - CNT_W'(1);
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_next};

  // Result decode
  always_comb begin
    res_next.id     = '0;
    res_next.valid  = 1'b0;
    res_next.status = ST_OK;
    res_next.count  = cnt_ext[CNT_OUT_W-1:0];
    unique case (cmd.op)
      OP_INSERT: begin
        if (full) res_next.status = ST_FULL;
      end
      OP_REMOVE: begin
        if (empty) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.id    = id_q[0];
          res_next.valid = 1'b1;
        end
      end
      default: res_next.status = ST_OK;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take)           res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

endmodule

FILE: src/priority_ready_queue.sv
// Top level of the priority ready queue: front end with command queue,
// sorted cell chain back end. Depends on prq_pkg, prq_front, prq_back.
//
//  channel | dir | tdata                          | tuser
//  s_*     | in  | [3:0] proc_id, [11:4] prio     | [0] action
//  m_*     | out | [3:0] removed_id, [8:4] count  | [0] removed_valid, [2:1] status
//
// The back end finishes one command per cycle unless the output stalls: the
// compare-and-shift over the cell chain is done in one update. An input
// transaction passes through the command queue, then the result register.
// Reset clears the entry count and the queue controls; cell contents are not
// cleared. A stalled output holds the result register and the back end; the
// two-entry command queue keeps accepting until it fills.
module priority_ready_queue #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [3:0] proc_id, [11:4] prio, [15:12] zero
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] removed_id, [8:4] entry_count, [15:9] zero
  output logic [2:0]  m_tuser    // [0] removed_valid, [2:1] status
);
  import prq_pkg::*;

  localparam logic [CNT_OUT_W-1:0] DEPTH_LO = CNT_OUT_W'(DEPTH);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  prq_front #(
    .PRIO_BITS (PRIO_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  prq_back #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Output packing
  assign m_tdata = {7'd0, res.count, res.id};
  assign m_tuser = {res.status, res.valid};

`ifndef SYNTHESIS
  // A stalled command must hold in the queue
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command changed while stalled");

  // A rejected insert reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status == ST_FULL |-> res.count == DEPTH_LO && !res.valid)
    else $error("full status with wrong count");

  // A remove on empty reports nothing held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status == ST_EMPTY |-> res.count == '0 && !res.valid && res.id == '0)
    else $error("empty status with wrong fields");

  // A returned entry always comes with ok status
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.valid |-> res.status == ST_OK)
    else $error("removed entry with error status");
`endif

endmodule
